FILE: src/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Scan modes, token kinds, error codes, transaction payloads, keyword table.
// ----------------------------------------------------------------------------
package stt_pkg;

  typedef enum logic [3:0] {
    M_IDLE, M_SYMBOL, M_SIGN_MINUS, M_SIGN_PLUS, M_INT, M_INTDOT, M_FRAC,
    M_BANG, M_LESS, M_GREATER, M_STRING, M_COMMENT
  } mode_t;

  localparam logic [5:0] K_LPAREN   = 6'd0;
  localparam logic [5:0] K_RPAREN   = 6'd1;
  localparam logic [5:0] K_LBRACKET = 6'd2;
  localparam logic [5:0] K_RBRACKET = 6'd3;
  localparam logic [5:0] K_LBRACE   = 6'd4;
  localparam logic [5:0] K_RBRACE   = 6'd5;
  localparam logic [5:0] K_COMMA    = 6'd6;
  localparam logic [5:0] K_DOT      = 6'd7;
  localparam logic [5:0] K_MINUS    = 6'd8;
  localparam logic [5:0] K_PLUS     = 6'd9;
  localparam logic [5:0] K_STAR     = 6'd10;
  localparam logic [5:0] K_BANG     = 6'd11;
  localparam logic [5:0] K_BANG_EQ  = 6'd12;
  localparam logic [5:0] K_LESS     = 6'd13;
  localparam logic [5:0] K_LESS_EQ  = 6'd14;
  localparam logic [5:0] K_GREATER  = 6'd15;
  localparam logic [5:0] K_GREATER_EQ = 6'd16;
  localparam logic [5:0] K_STRING   = 6'd17;
  localparam logic [5:0] K_INT      = 6'd18;
  localparam logic [5:0] K_FLOAT    = 6'd19;
  localparam logic [5:0] K_SYMBOL   = 6'd20;
  localparam logic [5:0] K_KEYWORD0 = 6'd21;
  localparam logic [5:0] K_EOF      = 6'd39;
  localparam logic [5:0] K_ERROR    = 6'd40;

  localparam logic [1:0] E_NONE     = 2'd0;
  localparam logic [1:0] E_UNEXPECTED = 2'd1;
  localparam logic [1:0] E_UNTERMINATED = 2'd2;
  localparam logic [1:0] E_OVERFLOW = 2'd3;

  localparam int NUM_KW = 18;

  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    "and", "class", "def", "defclass", "defn", "false", "for", "fn", "if",
    "let", "nil", "or", "print", "super", "this", "true", "var", "while"
  };
  localparam int KW_LEN [NUM_KW] = '{3, 5, 3, 8, 4, 5, 3, 2, 2, 3, 3, 2, 5, 5, 4, 4, 3, 5};

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         token_kind;
    logic [31:0]        start_offset;
    logic [15:0]        token_length;
    logic [31:0]        line_number;
    logic signed [31:0] int_value;
    logic [1:0]         error_code;
    logic               last_of_run;
  } tok_t;

  typedef struct packed {
    logic [1:0]     count;
    tok_t [2:0]     item;
  } push_t;

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alp(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic [5:0] kw_kind(input logic [63:0] pre, input logic [15:0] len);
    logic [5:0] k;
    logic       hit;
    int         idx;
    k = K_SYMBOL;
    for (int i = NUM_KW - 1; i >= 0; i--) begin
      hit = (len == 16'(KW_LEN[i]));
      for (int j = 0; j < 8; j++) begin
        idx = (j < KW_LEN[i]) ? (KW_LEN[i] - 1 - j) : 0;
        if ((j < KW_LEN[i]) && (pre[8*j +: 8] != KW_TEXT[i][8*idx +: 8])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        k = K_KEYWORD0 + 6'(i);
      end
    end
    return k;
  endfunction

endpackage

FILE: src/stt_scan.sv
// ----------------------------------------------------------------------------
// stt_scan: tokenizer scan state and per-byte step
// Holds the scan state and turns one accepted byte into up to three tokens.
// ----------------------------------------------------------------------------
module stt_scan import stt_pkg::*; #(
  parameter int KEYWORD_CHARS = 8,
  parameter int POSITION_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t in_item,
  output push_t    push
);

  localparam int PB  = POSITION_BITS;
  localparam int KC  = KEYWORD_CHARS;
  localparam int KIB = $clog2(KC);

  mode_t                mode_r, mode_nxt;
  logic [PB-1:0]        ts_r, ts_nxt;
  logic [PB-1:0]        pos_r, pos_nxt;
  logic [31:0]          line_r, line_nxt;
  logic [31:0]          acc_r, acc_nxt;
  logic                 neg_r, neg_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [KC-1:0][7:0]   pre_r, pre_nxt;
  logic [15:0]          len_r, len_nxt;

  tok_t [2:0]           res;
  logic [1:0]           n;

  function automatic logic [31:0] sat_off(input logic [PB-1:0] p);
    return (p > PB'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(p);
  endfunction

  function automatic tok_t mk(input logic [5:0] k, input logic [PB-1:0] s,
                              input logic [15:0] l, input logic [31:0] v,
                              input logic [1:0] e);
    tok_t t;
    t.token_kind   = k;
    t.start_offset = sat_off(s);
    t.token_length = l;
    t.line_number  = 32'd0;
    t.int_value    = v;
    t.error_code   = e;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  always_comb begin
    logic [7:0]  c;
    logic [31:0] d;
    logic        again;
    logic [35:0] v;
    logic [35:0] lim;
    logic [31:0] ival;
    logic [15:0] len_inc;
    logic [PB-1:0] prev;
    c       = in_item.byte_value;
    d       = {28'd0, c[3:0]};
    again   = 1'b0;
    len_inc = (len_r != 16'hFFFF) ? len_r + 16'd1 : len_r;
    prev    = (pos_r == '0) ? '0 : pos_r - PB'(1);
    ival    = neg_r ? 32'(32'd0 - acc_r) : acc_r;
    lim     = neg_r ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;
    v       = {4'd0, acc_r} * 36'd10 + {4'd0, d};
    n       = 2'd0;
    res     = '0;
    mode_nxt = mode_r;
    ts_nxt   = ts_r;
    pos_nxt  = pos_r;
    line_nxt = line_r;
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    ovf_nxt  = ovf_r;
    pre_nxt  = pre_r;
    len_nxt  = len_r;

    if (in_item.end_of_source) begin
      if (mode_r == M_STRING) begin
        res[n] = mk(K_ERROR, ts_r, len_r, 32'd0, E_UNTERMINATED);
        n = n + 2'd1;
      end
    end else begin
      unique case (mode_r)
        M_SYMBOL: begin
          if (is_alp(c) || is_dig(c)) begin
            if (len_r < 16'(KC)) begin
              pre_nxt[len_r[KIB-1:0]] = c;
            end
            len_nxt = len_inc;
          end else begin
            again = 1'b1;
          end
        end
        M_SIGN_MINUS, M_SIGN_PLUS: begin
          if (is_dig(c)) begin
            neg_nxt  = (mode_r == M_SIGN_MINUS);
            ovf_nxt  = 1'b0;
            acc_nxt  = d;
            mode_nxt = M_INT;
            len_nxt  = len_inc;
          end else begin
            again = 1'b1;
          end
        end
        M_INT: begin
          if (is_dig(c)) begin
            if (v > lim) begin
              acc_nxt = lim[31:0];
              ovf_nxt = 1'b1;
            end else begin
              acc_nxt = v[31:0];
            end
            len_nxt = len_inc;
          end else if (c == ".") begin
            mode_nxt = M_INTDOT;
            len_nxt  = len_inc;
          end else begin
            again = 1'b1;
          end
        end
        M_INTDOT, M_FRAC: begin
          if (is_dig(c)) begin
            mode_nxt = M_FRAC;
            len_nxt  = len_inc;
          end else begin
            again = 1'b1;
          end
        end
        M_BANG, M_LESS, M_GREATER: begin
          if (c == "=") begin
            res[n] = mk((mode_r == M_BANG) ? K_BANG_EQ :
                        (mode_r == M_LESS) ? K_LESS_EQ : K_GREATER_EQ,
                        ts_r, 16'd2, 32'd0, E_NONE);
            n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            again = 1'b1;
          end
        end
        M_STRING: begin
          if (c == "\"") begin
            res[n] = mk(K_STRING, ts_r, len_r, 32'd0, E_NONE);
            n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            if ((c == 8'h0A) && (line_r != 32'hFFFF_FFFF)) begin
              line_nxt = line_r + 32'd1;
            end
            len_nxt = len_inc;
          end
        end
        M_COMMENT: begin
          if (c == 8'h0A) begin
            mode_nxt = M_IDLE;
            again    = 1'b1;
          end
        end
        default: begin
          mode_nxt = M_IDLE;
          again    = 1'b1;
        end
      endcase
    end

    if (in_item.end_of_source || again) begin
      unique case (mode_r)
        M_SYMBOL: begin
          res[n] = mk(kw_kind(pre_r[7:0], len_r), ts_r, len_r, 32'd0, E_NONE);
          n = n + 2'd1;
        end
        M_SIGN_MINUS: begin
          res[n] = mk(K_MINUS, ts_r, 16'd1, 32'd0, E_NONE);
          n = n + 2'd1;
        end
        M_SIGN_PLUS: begin
          res[n] = mk(K_PLUS, ts_r, 16'd1, 32'd0, E_NONE);
          n = n + 2'd1;
        end
        M_INT: begin
          res[n] = mk(K_INT, ts_r, len_r, ival, ovf_r ? E_OVERFLOW : E_NONE);
          n = n + 2'd1;
        end
        M_INTDOT: begin
          res[n] = mk(K_INT, ts_r, len_r - 16'd1, ival, ovf_r ? E_OVERFLOW : E_NONE);
          n = n + 2'd1;
          res[n] = mk(K_DOT, prev, 16'd1, 32'd0, E_NONE);
          n = n + 2'd1;
        end
        M_FRAC: begin
          res[n] = mk(K_FLOAT, ts_r, len_r, 32'd0, E_NONE);
          n = n + 2'd1;
        end
        M_BANG: begin
          res[n] = mk(K_BANG, ts_r, 16'd1, 32'd0, E_NONE);
          n = n + 2'd1;
        end
        M_LESS: begin
          res[n] = mk(K_LESS, ts_r, 16'd1, 32'd0, E_NONE);
          n = n + 2'd1;
        end
        M_GREATER: begin
          res[n] = mk(K_GREATER, ts_r, 16'd1, 32'd0, E_NONE);
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      mode_nxt = M_IDLE;
    end

    if (in_item.end_of_source) begin
      res[n] = mk(K_EOF, pos_r, 16'd0, 32'd0, E_NONE);
      n = n + 2'd1;
      mode_nxt = M_IDLE;
      ts_nxt   = '0;
      pos_nxt  = '0;
      line_nxt = 32'd1;
      acc_nxt  = 32'd0;
      neg_nxt  = 1'b0;
      ovf_nxt  = 1'b0;
      pre_nxt  = '0;
      len_nxt  = 16'd0;
    end else begin
      if (again) begin
        priority case (1'b1)
          (c == "("): begin res[n] = mk(K_LPAREN, pos_r, 16'd1, 32'd0, E_NONE); n = n + 2'd1; end
          (c == ")"): begin res[n] = mk(K_RPAREN, pos_r, 16'd1, 32'd0, E_NONE); n = n + 2'd1; end
          (c == "["): begin res[n] = mk(K_LBRACKET, pos_r, 16'd1, 32'd0, E_NONE); n = n + 2'd1; end
          (c == "]"): begin res[n] = mk(K_RBRACKET, pos_r, 16'd1, 32'd0, E_NONE); n = n + 2'd1; end
          (c == "{"): begin res[n] = mk(K_LBRACE, pos_r, 16'd1, 32'd0, E_NONE); n = n + 2'd1; end
          (c == "}"): begin res[n] = mk(K_RBRACE, pos_r, 16'd1, 32'd0, E_NONE); n = n + 2'd1; end
          (c == ","): begin res[n] = mk(K_COMMA, pos_r, 16'd1, 32'd0, E_NONE); n = n + 2'd1; end
          (c == "."): begin res[n] = mk(K_DOT, pos_r, 16'd1, 32'd0, E_NONE); n = n + 2'd1; end
          (c == "*"): begin res[n] = mk(K_STAR, pos_r, 16'd1, 32'd0, E_NONE); n = n + 2'd1; end
          (c == "-"): begin mode_nxt = M_SIGN_MINUS; ts_nxt = pos_r; len_nxt = 16'd1; end
          (c == "+"): begin mode_nxt = M_SIGN_PLUS; ts_nxt = pos_r; len_nxt = 16'd1; end
          (c == "!"): begin mode_nxt = M_BANG; ts_nxt = pos_r; len_nxt = 16'd1; end
          (c == "<"): begin mode_nxt = M_LESS; ts_nxt = pos_r; len_nxt = 16'd1; end
          (c == ">"): begin mode_nxt = M_GREATER; ts_nxt = pos_r; len_nxt = 16'd1; end
          (c == ";"): begin mode_nxt = M_COMMENT; end
          (c == "\""): begin mode_nxt = M_STRING; ts_nxt = pos_r; len_nxt = 16'd0; end
          ((c == " ") || (c == 8'h0D) || (c == 8'h09)): begin end
          (c == 8'h0A): begin
            if (line_r != 32'hFFFF_FFFF) begin
              line_nxt = line_r + 32'd1;
            end
          end
          is_dig(c): begin
            mode_nxt = M_INT;
            ts_nxt   = pos_r;
            len_nxt  = 16'd1;
            acc_nxt  = d;
            neg_nxt  = 1'b0;
            ovf_nxt  = 1'b0;
          end
          is_alp(c): begin
            mode_nxt   = M_SYMBOL;
            ts_nxt     = pos_r;
            len_nxt    = 16'd1;
            pre_nxt    = '0;
            pre_nxt[0] = c;
          end
          default: begin
            res[n] = mk(K_ERROR, pos_r, 16'd1, 32'd0, E_UNEXPECTED);
            n = n + 2'd1;
          end
        endcase
      end
      if (pos_r != '1) begin
        pos_nxt = pos_r + PB'(1);
      end
    end

    for (int i = 0; i < 3; i++) begin
      res[i].line_number = line_r;
    end
    if (n != 2'd0) begin
      res[n - 2'd1].last_of_run = 1'b1;
    end
  end

  assign push.count = accept ? n : 2'd0;
  assign push.item  = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      ts_r   <= '0;
      pos_r  <= '0;
      line_r <= 32'd1;
      acc_r  <= 32'd0;
      neg_r  <= 1'b0;
      ovf_r  <= 1'b0;
      pre_r  <= '0;
      len_r  <= 16'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      ts_r   <= ts_nxt;
      pos_r  <= pos_nxt;
      line_r <= line_nxt;
      acc_r  <= acc_nxt;
      neg_r  <= neg_nxt;
      ovf_r  <= ovf_nxt;
      pre_r  <= pre_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

FILE: src/source_text_tokenizer.sv
// Queueing: a token is written into the registered result queue when the byte
// that completes it is accepted. Throughput: one byte per cycle while each byte
// yields at most one token and out_stall is low; in_stall is raised while the
// four-entry queue holds two or more tokens; it pops a token per unstalled cycle.
// Reset: synchronous, active low; scan state returns to idle, offset 0, line 1.
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming lexical tokenizer
// Scans one source byte per transaction and queues the resulting tokens.
// ----------------------------------------------------------------------------
module source_text_tokenizer import stt_pkg::*; #(
  parameter int KEYWORD_CHARS = 8,
  parameter int POSITION_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tok_t     out_data
);

  tok_t        q_r [4];
  logic [1:0]  wr_r, rd_r;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        accept, pop;
  push_t       push;

  assign in_stall  = (cnt_r > 3'd1);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = q_r[rd_r];
  assign cnt_nxt   = cnt_r + {1'b0, push.count} - {2'd0, pop};

  stt_scan #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_data),
    .push    (push)
  );

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push.count) begin
        q_r[wr_r + 2'(i)] <= push.item[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 2'd0;
      rd_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wr_r  <= wr_r + push.count;
      rd_r  <= rd_r + {1'b0, pop};
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: tb/source_text_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_tb: self-checking bench for the source tokenizer
// Feeds directed and random source text, predicts the tokens in a local
// scanner model and compares every output transaction in order.
// ----------------------------------------------------------------------------
module source_text_tokenizer_tb;
  import stt_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_item_t in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b1;
  tok_t     out_data;

  source_text_tokenizer i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scanner state
  mode_t       mode;
  logic [31:0] tok_start;
  logic [31:0] pos;
  logic [31:0] line;
  logic [31:0] acc;
  logic        neg;
  logic        ovf;
  logic [63:0] prefix;
  logic [15:0] sym_len;

  tok_t token_q[$];
  tok_t step_toks[$];
  int   errors = 0;
  int   cycles = 0;
  int   hold_off = 0;
  int   sent = 0;
  bit   done = 0;

  function automatic bit dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alp(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  task automatic scan_reset();
    mode = M_IDLE; tok_start = 32'd0; pos = 32'd0; line = 32'd1; acc = 32'd0;
    neg = 1'b0; ovf = 1'b0; prefix = '0; sym_len = 16'd0;
  endtask

  task automatic add_tok(logic [5:0] k, logic [31:0] s, logic [15:0] l,
                         logic [31:0] v, logic [1:0] e);
    tok_t t;
    t.token_kind = k; t.start_offset = s; t.token_length = l;
    t.line_number = line; t.int_value = v; t.error_code = e; t.last_of_run = 1'b0;
    step_toks.insert(step_toks.size(), t);
  endtask

  task automatic bump_len();
    if (sym_len != 16'hFFFF) sym_len++;
  endtask

  task automatic add_symbol();
    logic [5:0] k;
    bit         hit;
    k = K_SYMBOL;
    if (sym_len <= 16'd8) begin
      for (int i = NUM_KW - 1; i >= 0; i--) begin
        hit = sym_len == 16'(KW_LEN[i]);
        for (int j = 0; j < KW_LEN[i]; j++)
          if (prefix[8*j +: 8] != KW_TEXT[i][8*(KW_LEN[i]-1-j) +: 8]) hit = 1'b0;
        if (hit) k = K_KEYWORD0 + 6'(i);
      end
    end
    add_tok(k, tok_start, sym_len, 32'd0, E_NONE);
  endtask

  task automatic add_int(logic [15:0] l);
    add_tok(K_INT, tok_start, l, neg ? 32'(32'd0 - acc) : acc,
            ovf ? E_OVERFLOW : E_NONE);
  endtask

  task automatic flush_pending();
    case (mode)
      M_SYMBOL:     add_symbol();
      M_SIGN_MINUS: add_tok(K_MINUS, tok_start, 16'd1, 32'd0, E_NONE);
      M_SIGN_PLUS:  add_tok(K_PLUS, tok_start, 16'd1, 32'd0, E_NONE);
      M_INT:        add_int(sym_len);
      M_INTDOT: begin
        add_int(sym_len - 16'd1);
        add_tok(K_DOT, pos == 32'd0 ? 32'd0 : pos - 32'd1, 16'd1, 32'd0, E_NONE);
      end
      M_FRAC:       add_tok(K_FLOAT, tok_start, sym_len, 32'd0, E_NONE);
      M_BANG:       add_tok(K_BANG, tok_start, 16'd1, 32'd0, E_NONE);
      M_LESS:       add_tok(K_LESS, tok_start, 16'd1, 32'd0, E_NONE);
      M_GREATER:    add_tok(K_GREATER, tok_start, 16'd1, 32'd0, E_NONE);
      default: ;
    endcase
    mode = M_IDLE;
  endtask

  task automatic open_tok(mode_t m);
    mode = m; tok_start = pos; sym_len = 16'd1;
  endtask

  task automatic scan_fresh(logic [7:0] c);
    case (c)
      "(": add_tok(K_LPAREN, pos, 16'd1, 32'd0, E_NONE);
      ")": add_tok(K_RPAREN, pos, 16'd1, 32'd0, E_NONE);
      "[": add_tok(K_LBRACKET, pos, 16'd1, 32'd0, E_NONE);
      "]": add_tok(K_RBRACKET, pos, 16'd1, 32'd0, E_NONE);
      "{": add_tok(K_LBRACE, pos, 16'd1, 32'd0, E_NONE);
      "}": add_tok(K_RBRACE, pos, 16'd1, 32'd0, E_NONE);
      ",": add_tok(K_COMMA, pos, 16'd1, 32'd0, E_NONE);
      ".": add_tok(K_DOT, pos, 16'd1, 32'd0, E_NONE);
      "*": add_tok(K_STAR, pos, 16'd1, 32'd0, E_NONE);
      "-": open_tok(M_SIGN_MINUS);
      "+": open_tok(M_SIGN_PLUS);
      "!": open_tok(M_BANG);
      "<": open_tok(M_LESS);
      ">": open_tok(M_GREATER);
      ";": mode = M_COMMENT;
      8'h22: begin
        open_tok(M_STRING);
        sym_len = 16'd0;
      end
      8'h20, 8'h0D, 8'h09: ;
      8'h0A: if (line != '1) line++;
      default: begin
        if (dig(c)) begin
          open_tok(M_INT);
          acc = 32'(c - "0"); neg = 1'b0; ovf = 1'b0;
        end else if (alp(c)) begin
          open_tok(M_SYMBOL);
          prefix = '0; prefix[7:0] = c;
        end else begin
          add_tok(K_ERROR, pos, 16'd1, 32'd0, E_UNEXPECTED);
        end
      end
    endcase
  endtask

  task automatic predict_tokens(in_item_t it);
    logic [7:0]  c;
    bit          again;
    logic [63:0] v;
    logic [63:0] lim;
    c = it.byte_value;
    again = 1'b0;
    step_toks.delete();
    if (it.end_of_source) begin
      if (mode == M_STRING) add_tok(K_ERROR, tok_start, sym_len, 32'd0, E_UNTERMINATED);
      flush_pending();
      add_tok(K_EOF, pos, 16'd0, 32'd0, E_NONE);
      scan_reset();
    end else begin
      case (mode)
        M_SYMBOL:
          if (alp(c) || dig(c)) begin
            if (sym_len < 16'd8) prefix[8*sym_len[2:0] +: 8] = c;
            bump_len();
          end else again = 1'b1;
        M_SIGN_MINUS, M_SIGN_PLUS:
          if (dig(c)) begin
            neg = mode == M_SIGN_MINUS; ovf = 1'b0; acc = 32'(c - "0");
            mode = M_INT; bump_len();
          end else again = 1'b1;
        M_INT:
          if (dig(c)) begin
            lim = neg ? 64'd2147483648 : 64'd2147483647;
            v = 64'(acc) * 64'd10 + 64'(c - "0");
            if (v > lim) begin
              v = lim; ovf = 1'b1;
            end
            acc = v[31:0]; bump_len();
          end else if (c == ".") begin
            mode = M_INTDOT; bump_len();
          end else again = 1'b1;
        M_INTDOT, M_FRAC:
          if (dig(c)) begin
            mode = M_FRAC; bump_len();
          end else again = 1'b1;
        M_BANG, M_LESS, M_GREATER:
          if (c == "=") begin
            add_tok(mode == M_BANG ? K_BANG_EQ : mode == M_LESS ? K_LESS_EQ : K_GREATER_EQ,
                    tok_start, 16'd2, 32'd0, E_NONE);
            mode = M_IDLE;
          end else again = 1'b1;
        M_STRING:
          if (c == 8'h22) begin
            add_tok(K_STRING, tok_start, sym_len, 32'd0, E_NONE);
            mode = M_IDLE;
          end else begin
            if (c == 8'h0A && line != '1) line++;
            bump_len();
          end
        M_COMMENT:
          if (c == 8'h0A) begin
            mode = M_IDLE; again = 1'b1;
          end
        default: begin
          mode = M_IDLE; again = 1'b1;
        end
      endcase
      if (again) begin
        flush_pending();
        scan_fresh(c);
      end
      if (pos != '1) pos++;
    end
    if (step_toks.size() > 0) step_toks[$].last_of_run = 1'b1;
    foreach (step_toks[i]) token_q.insert(token_q.size(), step_toks[i]);
  endtask

  task automatic send_byte(logic [7:0] c, bit eos = 1'b0);
    in_item_t it;
    int       gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_data <= '0;
      repeat (gap) @(negedge clk);
    end
    it.byte_value = c;
    it.end_of_source = eos;
    in_data <= it;
    in_valid <= 1'b1;
    sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tokens(it);
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    in_data <= '0;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic end_source();
    send_byte(8'($urandom), 1'b1);
  endtask

  // receiver
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if (rst_n) begin
      out_stall <= ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
    end
  end

  always @(posedge clk) begin
    tok_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected token %p", out_data);
      end else begin
        want = token_q.pop_front();
        if (out_data !== want) begin
          errors++;
          if (errors <= 10) $display("expected %p actual %p", want, out_data);
        end
      end
    end
    if (cycles > 400000 && !done) begin
      $display("source_text_tokenizer: mismatch");
      $finish;
    end
  end

  task automatic test_punctuation();
    send_text("()[]{},.*!!=<<=>>=");
    send_byte(8'h0B);
    send_byte(8'hFF);
    send_byte(8'h80);
    end_source();
  endtask

  task automatic test_numbers();
    send_text("-7 +3 - 1.5 2147483648 -2147483649 +x 0.x 9");
    end_source();
    send_byte("-");
    end_source();
  endtask

  task automatic test_keywords();
    send_text("and defclass or while defclassx _Ab9 ;n\n\"a\nb\" \"o");
    end_source();
  endtask

  task automatic test_random_text();
    string pieces[] = '{"(", ")", "[", "]", "{", "}", ",", ".", "*", "-", "+",
      "!", "!=", "<", "<=", ">", ">=", "and", "while", "print", "x_1", "foo",
      "42", "-13", "+8", "3.14", "7.", "99999999999", "\"s t\"", "\"a\nb\"",
      ";c\n", "\n", " ", "\t", "\r", "=", "@", "if", "nil", "defn"};
    while (sent < 150) begin
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom));
      end else begin
        send_text(pieces[$urandom_range(0, pieces.size() - 1)]);
        if ($urandom_range(0, 1)) begin
          send_byte(" ");
        end
      end
      if ($urandom_range(0, 30) == 0) end_source();
    end
    end_source();
  endtask

  task automatic test_backpressure();
    hold_off = 60;
    send_text("(a,b) <= 1.x ");
    end_source();
  endtask

  initial begin
    scan_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_punctuation();
    test_numbers();
    test_keywords();
    test_backpressure();
    test_random_text();
    go_idle();
    while (token_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    done = 1;
    if (errors == 0) $display("source_text_tokenizer: match");
    else $display("source_text_tokenizer: mismatch");
    $finish;
  end
endmodule

FILE: sim.f
src/stt_pkg.sv
src/stt_scan.sv
src/source_text_tokenizer.sv
tb/source_text_tokenizer_tb.sv
